FILE: rtl/rtcet_pkg.sv
// Shared types, codes and helper functions for the elapsed-time RTC block.
package rtcet_pkg;

    // Field widths of one transfer.
    localparam int OP_W   = 2;
    localparam int SEL_W  = 4;
    localparam int DATA_W = 8;

    // Widths of the mixed-radix time fields.
    localparam int SEC_W  = 6;
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;
    localparam int DAY_W  = 9;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // Register selects.
    localparam logic [SEL_W-1:0] SEL_SEC    = 4'd8;
    localparam logic [SEL_W-1:0] SEL_MIN    = 4'd9;
    localparam logic [SEL_W-1:0] SEL_HOUR   = 4'd10;
    localparam logic [SEL_W-1:0] SEL_DAY_LO = 4'd11;
    localparam logic [SEL_W-1:0] SEL_DAY_HI = 4'd12;

    // Last legal value of each wrapping field.
    localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEL_W-1:0]  reg_select;
        logic [DATA_W-1:0] write_data;
    } t_item;

    // Byte reduced mod 60 by three conditional subtractions.
    function automatic logic [SEC_W-1:0] mod60(input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        r = d;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r[SEC_W-1:0];
    endfunction

    // Byte reduced mod 24 by four conditional subtractions.
    function automatic logic [HOUR_W-1:0] mod24(input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        r = d;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r[HOUR_W-1:0];
    endfunction

endpackage

FILE: rtl/rtcet_in_stage.sv
// Input register stage that captures one item per transfer.
module rtcet_in_stage
    import rtcet_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // The stage takes a new item when empty or when its item moves on.
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/rtcet_time_core.sv
// Time fields, their update per item, and the result register.
module rtcet_time_core
    import rtcet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic              i_ready,
    output logic              o_advance,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_read_data
);

    logic [SEC_W-1:0]  r_sec,  n_sec;
    logic [MIN_W-1:0]  r_min,  n_min;
    logic [HOUR_W-1:0] r_hour, n_hour;
    logic [DAY_W-1:0]  r_day,  n_day;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic [DATA_W-1:0] read_val;
    logic              fire;

    // The item moves into the result register when that register is free or drains.
    assign o_advance = !r_out_valid || i_ready;
    assign fire      = i_valid && o_advance;

    // Field selected by a read.
    always_comb begin
        case (i_item.reg_select)
            SEL_SEC:    read_val = {{(DATA_W-SEC_W){1'b0}}, r_sec};
            SEL_MIN:    read_val = {{(DATA_W-MIN_W){1'b0}}, r_min};
            SEL_HOUR:   read_val = {{(DATA_W-HOUR_W){1'b0}}, r_hour};
            SEL_DAY_LO: read_val = r_day[DATA_W-1:0];
            SEL_DAY_HI: read_val = {{(DATA_W-1){1'b0}}, r_day[DAY_W-1]};
            default:    read_val = '0;
        endcase
    end

    // Next state of the clock fields.
    always_comb begin
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        n_day  = r_day;
        if (fire) begin
            case (i_item.op)
                OP_WRITE: begin
                    case (i_item.reg_select)
                        SEL_SEC:    n_sec  = mod60(i_item.write_data);
                        SEL_MIN:    n_min  = mod60(i_item.write_data);
                        SEL_HOUR:   n_hour = mod24(i_item.write_data);
                        SEL_DAY_LO: n_day  = {r_day[DAY_W-1], i_item.write_data};
                        SEL_DAY_HI: n_day  = {i_item.write_data[0], r_day[DATA_W-1:0]};
                        default:    n_day  = r_day;
                    endcase
                end
                OP_TICK: begin
                    // Ripple carry through seconds, minutes, hours and days.
                    if (r_sec == SEC_MAX) begin
                        n_sec = '0;
                        if (r_min == MIN_MAX) begin
                            n_min = '0;
                            if (r_hour == HOUR_MAX) begin
                                n_hour = '0;
                                n_day  = r_day + 1'b1;
                            end else begin
                                n_hour = r_hour + 1'b1;
                            end
                        end else begin
                            n_min = r_min + 1'b1;
                        end
                    end else begin
                        n_sec = r_sec + 1'b1;
                    end
                end
                default: begin
                    n_sec = r_sec;
                end
            endcase
        end
    end

    // Result valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_advance) begin
            n_out_valid = i_valid;
        end
    end

    // Clock fields and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_day       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sec       <= n_sec;
            r_min       <= n_min;
            r_hour      <= n_hour;
            r_day       <= n_day;
            r_out_valid <= n_out_valid;
        end
    end

    // Result data; only a read returns a nonzero byte.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data <= (i_item.op == OP_READ) ? read_val : '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

FILE: rtl/rtc_elapsed_time_registers.sv
// An item passes from the input register to the result register; an output stall holds the
// result in the result register and backs up the input register.
// Throughput: one item per cycle unless the output stalls; each register holds one item.
// A tick carries through the seconds, minutes, hours and day fields, a write sets one field, a read changes none.
// Reset (synchronous, active low) clears the elapsed time to zero and empties both stages.
// Top level of the elapsed-time real-time clock register block.
module rtc_elapsed_time_registers
    import rtcet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [SEL_W-1:0]  i_reg_select,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_read_data
);

    t_item in_item;
    t_item stage_item;
    logic  stage_valid;
    logic  advance;

    assign in_item = '{op: i_op, reg_select: i_reg_select, write_data: i_write_data};

    // Input register.
    rtcet_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_ready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // Clock fields and result register.
    rtcet_time_core u_time_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .i_ready     (i_ready),
        .o_advance   (advance),
        .o_valid     (o_valid),
        .o_read_data (o_read_data)
    );

endmodule

FILE: rtl/rtcet_checker.sv
// Port-level checker for the elapsed-time RTC block, bound to the top level.
module rtcet_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_op,
    input logic [3:0] i_reg_select,
    input logic [7:0] i_write_data,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data
);

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_data)))
        else $error("result changed while stalled");

    // The input side only backs up when a result is waiting and stalled.
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input not ready without an output stall");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind rtc_elapsed_time_registers rtcet_checker u_rtcet_checker (.*);
